// ===== hdl/sm3_pkg.sv =====
`default_nettype none
package sm3_pkg;

    localparam int WordW = 32;
    localparam int NumRounds = 64;
    localparam int BlockWords = 16;

    typedef logic [WordW-1:0] word_t;
    typedef logic [0:7][WordW-1:0] reg8_t;
    typedef logic [0:BlockWords-1][WordW-1:0] win_t;

    localparam reg8_t SM3_IV = {
        32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
        32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
    };
    localparam word_t T_LOW = 32'h79cc4519;
    localparam word_t T_HIGH = 32'h7a879d8a;
    localparam word_t PAD_WORD = 32'h80000000;
    localparam logic [5:0] FULL_BITS = 6'd32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMP,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load_wr;
        logic round_en;
        logic fold;
        logic init_cv;
    } core_ctrl_t;

    function automatic word_t rotl(input word_t x, input logic [4:0] k);
        logic [2*WordW-1:0] d;
        d = {x, x} << k;
        return d[2*WordW-1:WordW];
    endfunction

    function automatic word_t perm0(input word_t x);
        return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic word_t perm1(input word_t x);
        return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction

    function automatic word_t round_const(input logic [5:0] j);
        word_t t;
        t = (j < 6'd16) ? T_LOW : T_HIGH;
        return rotl(t, j[4:0]);
    endfunction

endpackage
`default_nettype wire

// ===== hdl/sm3_msg_sched.sv =====
`default_nettype none
module sm3_msg_sched (
    input  wire logic           aclk,
    input  wire logic           push,
    input  wire sm3_pkg::word_t push_word,
    input  wire logic           advance,
    output sm3_pkg::word_t      w_j,
    output sm3_pkg::word_t      wp_j
);

    sm3_pkg::win_t  win_reg;
    sm3_pkg::win_t  win_next;
    sm3_pkg::word_t expand_word;

    assign expand_word = sm3_pkg::perm1(win_reg[0] ^ win_reg[7]
                                        ^ sm3_pkg::rotl(win_reg[13], 5'd15))
                       ^ sm3_pkg::rotl(win_reg[3], 5'd7) ^ win_reg[10];

    assign w_j  = win_reg[0];
    assign wp_j = win_reg[0] ^ win_reg[4];

    always_comb begin
        win_next = win_reg;
        if (push || advance) begin
            for (int i = 0; i < sm3_pkg::BlockWords - 1; i++) begin
                win_next[i] = win_reg[i+1];
            end
            win_next[sm3_pkg::BlockWords-1] = push ? push_word : expand_word;
        end
    end

    always_ff @(posedge aclk) begin
        win_reg <= win_next;
    end

endmodule
`default_nettype wire

// ===== hdl/sm3_round_core.sv =====
`default_nettype none
module sm3_round_core (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire sm3_pkg::core_ctrl_t ctrl,
    input  wire logic [5:0]          round_idx,
    input  wire sm3_pkg::word_t      w_j,
    input  wire sm3_pkg::word_t      wp_j,
    output sm3_pkg::reg8_t           cv
);

    sm3_pkg::reg8_t cv_reg, cv_next;
    sm3_pkg::reg8_t wr_reg, wr_next;
    sm3_pkg::reg8_t rnd;
    sm3_pkg::word_t a12, ss1, ss2, ff, gg, tt1, tt2;
    logic           early;

    assign early = (round_idx < 6'd16);
    assign a12   = sm3_pkg::rotl(wr_reg[0], 5'd12);
    assign ss1   = sm3_pkg::rotl(a12 + wr_reg[4] + sm3_pkg::round_const(round_idx), 5'd7);
    assign ss2   = ss1 ^ a12;
    assign ff    = early ? (wr_reg[0] ^ wr_reg[1] ^ wr_reg[2])
                         : ((wr_reg[0] & wr_reg[1]) | (wr_reg[0] & wr_reg[2])
                            | (wr_reg[1] & wr_reg[2]));
    assign gg    = early ? (wr_reg[4] ^ wr_reg[5] ^ wr_reg[6])
                         : ((wr_reg[4] & wr_reg[5]) | (~wr_reg[4] & wr_reg[6]));
    assign tt1   = ff + wr_reg[3] + ss2 + wp_j;
    assign tt2   = gg + wr_reg[7] + ss1 + w_j;

    always_comb begin
        rnd[0] = tt1;
        rnd[1] = wr_reg[0];
        rnd[2] = sm3_pkg::rotl(wr_reg[1], 5'd9);
        rnd[3] = wr_reg[2];
        rnd[4] = sm3_pkg::perm0(tt2);
        rnd[5] = wr_reg[4];
        rnd[6] = sm3_pkg::rotl(wr_reg[5], 5'd19);
        rnd[7] = wr_reg[6];
    end

    always_comb begin
        wr_next = wr_reg;
        if (ctrl.load_wr) begin
            wr_next = cv_reg;
        end else if (ctrl.round_en) begin
            wr_next = rnd;
        end
    end

    always_comb begin
        cv_next = cv_reg;
        if (ctrl.init_cv) begin
            cv_next = sm3_pkg::SM3_IV;
        end else if (ctrl.fold) begin
            cv_next = cv_reg ^ rnd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cv_reg <= sm3_pkg::SM3_IV;
        end else begin
            cv_reg <= cv_next;
        end
    end

    always_ff @(posedge aclk) begin
        wr_reg <= wr_next;
    end

    assign cv = cv_reg;

endmodule
`default_nettype wire

// ===== hdl/sm3_hash_engine.sv =====
// A non-last beat that fills a block waits for its compression before the next beat is taken;
// other non-last beats do not stall the input. A last beat pads one word per cycle (up to 18 words),
// compresses one or two blocks at one round per cycle, then offers eight digest beats.
// Throughput is bounded by the single shared round unit: s_ready is high only in the idle state.
// Reset (aresetn low, synchronous): chaining value to the SM3 IV, length and counters cleared.
`default_nettype none
module sm3_hash_engine (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_msg_word,
    input  wire logic [5:0]  s_valid_bits,
    input  wire logic        s_last_word,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_digest_word,
    output logic             m_last_digest
);

    sm3_pkg::state_t     state_reg, state_next;
    logic [3:0]          pos_reg, pos_next;
    logic [5:0]          round_reg, round_next;
    logic [2:0]          out_idx_reg, out_idx_next;
    logic [63:0]         len_reg, len_next;
    logic                pad_one_reg, pad_one_next;
    logic                pad_active_reg, pad_active_next;
    logic                hi_done_reg, hi_done_next;
    logic                len_done_reg, len_done_next;

    logic                s_beat, m_beat, push;
    sm3_pkg::word_t      push_word, last_word_val, pad_src;
    logic [5:0]          vb_sat;
    sm3_pkg::core_ctrl_t core_ctrl;
    sm3_pkg::word_t      w_j, wp_j;
    sm3_pkg::reg8_t      cv;

    assign s_beat = s_valid && s_ready;
    assign m_beat = m_valid && m_ready;
    assign vb_sat = (s_valid_bits > sm3_pkg::FULL_BITS) ? sm3_pkg::FULL_BITS : s_valid_bits;

    always_comb begin
        if (vb_sat == sm3_pkg::FULL_BITS) begin
            last_word_val = s_msg_word;
        end else begin
            last_word_val = (s_msg_word & ~(32'hffffffff >> vb_sat))
                          | (sm3_pkg::PAD_WORD >> vb_sat);
        end
    end

    always_comb begin
        if (pad_one_reg) begin
            pad_src = sm3_pkg::PAD_WORD;
        end else if (pos_reg == 4'd14) begin
            pad_src = len_reg[63:32];
        end else if (pos_reg == 4'd15 && hi_done_reg) begin
            pad_src = len_reg[31:0];
        end else begin
            pad_src = '0;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sm3_pkg::ST_IDLE: begin
                if (s_beat) begin
                    if (pos_reg == 4'd15) begin
                        state_next = sm3_pkg::ST_COMP;
                    end else if (s_last_word) begin
                        state_next = sm3_pkg::ST_PAD;
                    end
                end
            end
            sm3_pkg::ST_PAD: begin
                if (pos_reg == 4'd15) begin
                    state_next = sm3_pkg::ST_COMP;
                end
            end
            sm3_pkg::ST_COMP: begin
                if (round_reg == 6'(sm3_pkg::NumRounds - 1)) begin
                    if (len_done_reg) begin
                        state_next = sm3_pkg::ST_OUT;
                    end else if (pad_active_reg) begin
                        state_next = sm3_pkg::ST_PAD;
                    end else begin
                        state_next = sm3_pkg::ST_IDLE;
                    end
                end
            end
            sm3_pkg::ST_OUT: begin
                if (m_beat && out_idx_reg == 3'd7) begin
                    state_next = sm3_pkg::ST_IDLE;
                end
            end
            default: state_next = sm3_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready           = (state_reg == sm3_pkg::ST_IDLE);
        m_valid           = (state_reg == sm3_pkg::ST_OUT);
        m_digest_word     = cv[out_idx_reg];
        m_last_digest     = (out_idx_reg == 3'd7);
        push              = s_beat || (state_reg == sm3_pkg::ST_PAD);
        push_word         = (state_reg == sm3_pkg::ST_PAD) ? pad_src
                          : (s_last_word ? last_word_val : s_msg_word);
        core_ctrl.load_wr  = push && (pos_reg == 4'd15);
        core_ctrl.round_en = (state_reg == sm3_pkg::ST_COMP);
        core_ctrl.fold     = (state_reg == sm3_pkg::ST_COMP)
                           && (round_reg == 6'(sm3_pkg::NumRounds - 1));
        core_ctrl.init_cv  = m_beat && (out_idx_reg == 3'd7);
    end

    always_comb begin
        pos_next        = pos_reg;
        round_next      = round_reg;
        out_idx_next    = out_idx_reg;
        len_next        = len_reg;
        pad_one_next    = pad_one_reg;
        pad_active_next = pad_active_reg;
        hi_done_next    = hi_done_reg;
        len_done_next   = len_done_reg;
        if (push) begin
            pos_next = pos_reg + 4'd1;
        end
        if (s_beat) begin
            len_next = len_reg + (s_last_word ? {58'd0, vb_sat} : 64'd32);
            if (s_last_word) begin
                pad_active_next = 1'b1;
                pad_one_next    = (vb_sat == sm3_pkg::FULL_BITS);
            end
        end
        if (state_reg == sm3_pkg::ST_PAD) begin
            if (pad_one_reg) begin
                pad_one_next = 1'b0;
            end else if (pos_reg == 4'd14) begin
                hi_done_next = 1'b1;
            end else if (pos_reg == 4'd15 && hi_done_reg) begin
                len_done_next = 1'b1;
            end
        end
        if (state_reg == sm3_pkg::ST_COMP) begin
            round_next = round_reg + 6'd1;
        end
        if (m_beat) begin
            out_idx_next = out_idx_reg + 3'd1;
            if (out_idx_reg == 3'd7) begin
                len_next        = '0;
                pos_next        = '0;
                pad_active_next = 1'b0;
                hi_done_next    = 1'b0;
                len_done_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= sm3_pkg::ST_IDLE;
            pos_reg        <= '0;
            round_reg      <= '0;
            out_idx_reg    <= '0;
            len_reg        <= '0;
            pad_one_reg    <= 1'b0;
            pad_active_reg <= 1'b0;
            hi_done_reg    <= 1'b0;
            len_done_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            round_reg      <= round_next;
            out_idx_reg    <= out_idx_next;
            len_reg        <= len_next;
            pad_one_reg    <= pad_one_next;
            pad_active_reg <= pad_active_next;
            hi_done_reg    <= hi_done_next;
            len_done_reg   <= len_done_next;
        end
    end

    sm3_msg_sched u_sched (
        .aclk      (aclk),
        .push      (push),
        .push_word (push_word),
        .advance   (core_ctrl.round_en),
        .w_j       (w_j),
        .wp_j      (wp_j)
    );

    sm3_round_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (core_ctrl),
        .round_idx (round_reg),
        .w_j       (w_j),
        .wp_j      (wp_j),
        .cv        (cv)
    );

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    typedef struct {
        logic [31:0] word;
        logic [5:0]  nbits;
        logic        last;
    } msg_beat_t;

    typedef struct {
        logic [31:0] word;
        logic        last;
    } digest_beat_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_msg_word = '0;
    logic [5:0]  s_valid_bits = '0;
    logic        s_last_word = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_digest_word;
    logic        m_last_digest;

    msg_beat_t    msg_beats[$];
    digest_beat_t digest_pending[$];
    digest_beat_t want;

    logic [31:0] cv_model[8];
    logic [31:0] blk_words[16];
    int unsigned blk_fill;
    logic [63:0] msg_len_bits;

    int errors = 0;
    int beats_taken = 0;
    int total_beats = 0;
    int digests_seen = 0;
    logic in_fire = 1'b0;
    logic out_fire = 1'b0;
    int send_gap = 0;
    int snd_burst = 0;
    int rdy_stall = 0;
    int rdy_burst = 0;
    bit hold_done = 1'b0;

    sm3_hash_engine u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_msg_word   (s_msg_word),
        .s_valid_bits (s_valid_bits),
        .s_last_word  (s_last_word),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_digest_word(m_digest_word),
        .m_last_digest(m_last_digest)
    );

    function automatic logic [31:0] rol32(input logic [31:0] x, input int unsigned n);
        int unsigned k;
        k = n % 32;
        if (k == 0) return x;
        return (x << k) | (x >> (32 - k));
    endfunction

    function automatic logic [31:0] mix_p0(input logic [31:0] x);
        return x ^ rol32(x, 9) ^ rol32(x, 17);
    endfunction

    function automatic logic [31:0] mix_p1(input logic [31:0] x);
        return x ^ rol32(x, 15) ^ rol32(x, 23);
    endfunction

    function automatic void compress_model();
        logic [31:0] w[68];
        logic [31:0] a, b, c, d, e, f, g, h;
        logic [31:0] a12, sum, ss1, ss2, ff, gg, tt1, tt2, tj;
        int j;
        for (j = 0; j < 16; j++) w[j] = blk_words[j];
        for (j = 16; j < 68; j++) begin
            w[j] = mix_p1(w[j-16] ^ w[j-9] ^ rol32(w[j-3], 15)) ^ rol32(w[j-13], 7) ^ w[j-6];
        end
        a = cv_model[0]; b = cv_model[1]; c = cv_model[2]; d = cv_model[3];
        e = cv_model[4]; f = cv_model[5]; g = cv_model[6]; h = cv_model[7];
        for (j = 0; j < 64; j++) begin
            tj = (j < 16) ? sm3_pkg::T_LOW : sm3_pkg::T_HIGH;
            a12 = rol32(a, 12);
            sum = a12 + e + rol32(tj, j);
            ss1 = rol32(sum, 7);
            ss2 = ss1 ^ a12;
            if (j < 16) begin
                ff = a ^ b ^ c;
                gg = e ^ f ^ g;
            end else begin
                ff = (a & b) | (a & c) | (b & c);
                gg = (e & f) | (~e & g);
            end
            tt1 = ff + d + ss2 + (w[j] ^ w[j+4]);
            tt2 = gg + h + ss1 + w[j];
            d = c; c = rol32(b, 9); b = a; a = tt1;
            h = g; g = rol32(f, 19); f = e; e = mix_p0(tt2);
        end
        cv_model[0] ^= a; cv_model[1] ^= b; cv_model[2] ^= c; cv_model[3] ^= d;
        cv_model[4] ^= e; cv_model[5] ^= f; cv_model[6] ^= g; cv_model[7] ^= h;
    endfunction

    function automatic void absorb_word(input logic [31:0] v);
        blk_words[blk_fill] = v;
        blk_fill++;
        if (blk_fill == 16) begin
            compress_model();
            blk_fill = 0;
        end
    endfunction

    function automatic void restart_model();
        for (int k = 0; k < 8; k++) cv_model[k] = sm3_pkg::SM3_IV[k];
        blk_fill = 0;
        msg_len_bits = '0;
    endfunction

    function automatic void hash_beat(input logic [31:0] word, input logic [5:0] nbits,
                                      input logic last);
        int unsigned nb;
        logic [31:0] mask;
        digest_beat_t d;
        if (!last) begin
            msg_len_bits += 64'd32;
            absorb_word(word);
            return;
        end
        nb = (nbits > 6'd32) ? 32 : nbits;
        msg_len_bits += 64'(nb);
        if (nb == 32) begin
            absorb_word(word);
            absorb_word(sm3_pkg::PAD_WORD);
        end else begin
            mask = (nb == 0) ? 32'h0 : (32'hffff_ffff << (32 - nb));
            absorb_word((word & mask) | (sm3_pkg::PAD_WORD >> nb));
        end
        if (blk_fill > 14) begin
            while (blk_fill != 0) absorb_word(32'h0);
        end
        while (blk_fill < 14) absorb_word(32'h0);
        absorb_word(msg_len_bits[63:32]);
        absorb_word(msg_len_bits[31:0]);
        for (int k = 0; k < 8; k++) begin
            d.word = cv_model[k];
            d.last = (k == 7);
            digest_pending.push_back(d);
        end
        restart_model();
    endfunction

    function automatic int pick_gap(inout int burst);
        int r;
        if (burst > 0) begin
            burst--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            burst = $urandom_range(10, 40);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic add_beat(input logic [31:0] word, input logic [5:0] nbits, input logic last);
        msg_beat_t b;
        b.word = word;
        b.nbits = nbits;
        b.last = last;
        msg_beats.push_back(b);
    endtask

    function automatic logic [31:0] rand_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 32'h0;
        if (r == 1) return 32'hffff_ffff;
        return $urandom;
    endfunction

    task automatic add_message(input int n_words);
        int r;
        logic [5:0] nb;
        for (int i = 0; i < n_words - 1; i++) begin
            add_beat(rand_word(), 6'($urandom_range(0, 63)), 1'b0);
        end
        r = $urandom_range(0, 9);
        if (r < 3) nb = 6'd32;
        else if (r == 3) nb = 6'd0;
        else nb = 6'($urandom_range(0, 63));
        add_beat(rand_word(), nb, 1'b1);
    endtask

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // drive message beats
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_fire) begin
            if (send_gap > 0) begin
                s_valid <= 1'b0;
                send_gap--;
            end else if (msg_beats.size() > 0) begin
                s_msg_word <= msg_beats[0].word;
                s_valid_bits <= msg_beats[0].nbits;
                s_last_word <= msg_beats[0].last;
                s_valid <= 1'b1;
                void'(msg_beats.pop_front());
                send_gap = pick_gap(snd_burst);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // backpressure on digest beats, with one long hold-off
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (!hold_done && digests_seen >= 16) begin
                hold_done = 1'b1;
                rdy_stall = 400;
            end else if (out_fire) begin
                rdy_stall = pick_gap(rdy_burst);
            end
            if (rdy_stall > 0) begin
                m_ready <= 1'b0;
                rdy_stall--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            in_fire <= 1'b0;
            out_fire <= 1'b0;
        end else begin
            in_fire <= s_valid && s_ready;
            out_fire <= m_valid && m_ready;
            if (m_valid && m_ready) begin
                digests_seen++;
                if (digest_pending.size() == 0) begin
                    $display("%0t: unexpected digest beat word=%h last=%b",
                             $time, m_digest_word, m_last_digest);
                    errors++;
                end else begin
                    want = digest_pending.pop_front();
                    if (m_digest_word !== want.word) begin
                        $display("%0t: digest_word mismatch expected %h actual %h",
                                 $time, want.word, m_digest_word);
                        errors++;
                    end
                    if (m_last_digest !== want.last) begin
                        $display("%0t: last_digest mismatch expected %b actual %b",
                                 $time, want.last, m_last_digest);
                        errors++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                beats_taken++;
                hash_beat(s_msg_word, s_valid_bits, s_last_word);
            end
        end
    end

    initial begin
        int r;
        restart_model();

        add_beat(32'hffff_ffff, 6'd0, 1'b1);
        add_beat(32'h6162_63a5, 6'd24, 1'b1);
        add_beat(32'hffff_ffff, 6'd32, 1'b1);
        add_beat(32'h1234_5678, 6'd63, 1'b1);
        add_beat(32'hffff_ffff, 6'd31, 1'b1);
        for (int i = 0; i < 13; i++) begin
            add_beat((i % 2) ? 32'hffff_ffff : 32'h0, (i % 2) ? 6'd63 : 6'd0, 1'b0);
        end
        add_beat(32'h8000_0001, 6'd32, 1'b1);
        add_beat(32'hdead_beef, 6'd5, 1'b0);
        add_beat(32'h7fff_ffff, 6'd1, 1'b1);

        while (msg_beats.size() < 112) begin
            r = $urandom_range(0, 9);
            if (r < 6) add_message($urandom_range(1, 16));
            else if (r < 9) add_message($urandom_range(12, 18));
            else add_message($urandom_range(17, 40));
        end
        total_beats = msg_beats.size();

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        while (beats_taken < total_beats) @(posedge aclk);
        while (digest_pending.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/sm3_pkg.sv
hdl/sm3_msg_sched.sv
hdl/sm3_round_core.sv
hdl/sm3_hash_engine.sv
sim/testbench.sv
